// File: src/teab_pkg.sv
// Shared types and constants of the triangle edge adjacency builder.
// Used by teab_front, teab_engine and the top level; depends on nothing.
package teab_pkg;

	localparam int VERT_W = 16;
	localparam int QFACE_W = 10;
	localparam int FACE_FIELD_W = 10;
	localparam int EDGE_FIELD_W = 11;
	localparam int STATUS_W = 3;

	// Command codes as they arrive on the input channel
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ADD,
		OP_QUERY,
		OP_NONE
	} op_t;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_OVER = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_OPEN = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_BAD = 3'd4;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_KEY,
		ST_HCK,
		ST_ECK,
		ST_RB,
		ST_COMMIT,
		ST_FRD,
		ST_DRD,
		ST_DCK,
		ST_FIN
	} state_t;

	// One classified command waiting in the queue
	typedef struct packed {
		op_t op;
		logic [VERT_W-1:0] va;
		logic [VERT_W-1:0] vb;
		logic [VERT_W-1:0] vc;
		logic [QFACE_W-1:0] fq;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FACE_FIELD_W-1:0] face;
		logic [2:0][EDGE_FIELD_W-1:0] eid;
		logic [2:0][FACE_FIELD_W-1:0] nb;
		logic [2:0] mask;
		logic solid;
	} res_t;

endpackage

// File: src/teab_front.sv
// Input side of the adjacency builder: accepts transactions, classifies the
// command and holds them in a two-entry queue. Depends on teab_pkg.
module teab_front (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [63:0] s_tdata,
	input logic [1:0] s_tuser,
	output logic head_valid,
	output teab_pkg::cmd_t head,
	input logic pop
);

	teab_pkg::cmd_t entry_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	teab_pkg::cmd_t cmd_c;
	logic push;

	// Classify the incoming command
	always_comb begin
		cmd_c.va = s_tdata[15:0];
		cmd_c.vb = s_tdata[31:16];
		cmd_c.vc = s_tdata[47:32];
		cmd_c.fq = s_tdata[57:48];
		unique case (s_tuser)
			teab_pkg::CMD_CLEAR: cmd_c.op = teab_pkg::OP_CLEAR;
			teab_pkg::CMD_ADD: cmd_c.op = teab_pkg::OP_ADD;
			teab_pkg::CMD_QUERY: cmd_c.op = teab_pkg::OP_QUERY;
			default: cmd_c.op = teab_pkg::OP_NONE;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign head_valid = (cnt_q != 2'd0);
	assign head = entry_q[rd_q];

	// Advance queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Store accepted commands
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= cmd_c;
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue level out of range");
	a_full_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2)) else $error("queue level lost");

endmodule

// File: src/teab_engine.sv
// Back part of the adjacency builder: hashed edge lookup, edge and face
// tables, rollback of rejected faces and the result register.
// Depends on teab_pkg.
module teab_engine #(
	parameter int MAX_FACES = 1024,
	parameter int MAX_EDGES = 1536,
	parameter int VERTEX_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input teab_pkg::cmd_t head,
	output logic pop,
	output logic res_valid,
	input logic res_ready,
	output teab_pkg::res_t res
);

	localparam int FCW = $clog2(MAX_FACES + 1);
	localparam int FIW = $clog2(MAX_FACES);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int EIW = $clog2(MAX_EDGES);
	localparam int HW = $clog2(MAX_EDGES) + 1;
	localparam int HD = 1 << HW;
	localparam int KW = 2 * VERTEX_BITS;
	localparam int EFW = 2 * FIW + 1;
	localparam int FFW = teab_pkg::FACE_FIELD_W;
	localparam int EDW = teab_pkg::EDGE_FIELD_W;
	localparam int QW = teab_pkg::QFACE_W;

	// Memories
	logic [ECW-1:0] hash_mem [HD];
	logic [KW-1:0] key_mem [MAX_EDGES];
	logic [EFW-1:0] ef_mem [MAX_EDGES];
	logic [3*EIW-1:0] fe_mem [MAX_FACES];

	logic [ECW-1:0] hr_q;
	logic [KW-1:0] kr_q;
	logic [EFW-1:0] efr_q;
	logic [3*EIW-1:0] fer_q;

	logic hw_en, kw_en, efw_en, few_en;
	logic [HW-1:0] hw_addr, hr_addr;
	logic [ECW-1:0] hw_data;
	logic [EIW-1:0] kw_addr, kr_addr, efw_addr, efr_addr;
	logic [KW-1:0] kw_data;
	logic [EFW-1:0] efw_data;
	logic [FIW-1:0] few_addr, fer_addr;
	logic [3*EIW-1:0] few_data;

	// Control and work registers
	teab_pkg::state_t state_q, state_d;
	teab_pkg::op_t op_q, op_d;
	logic [2:0][VERTEX_BITS-1:0] v_q, v_d;
	logic [FCW-1:0] fi_q, fi_d;
	logic [1:0] e_q, e_d;
	logic [KW-1:0] key_q, key_d;
	logic [HW-1:0] slot_q, slot_d;
	logic [EIW-1:0] id_q, id_d;
	logic [2:0][EIW-1:0] ids_q, ids_d;
	logic [1:0] tn_q, tn_d;
	logic [2:0][EIW-1:0] tid_q, tid_d;
	logic [2:0][FIW-1:0] tfirst_q, tfirst_d;
	logic [ECW-1:0] saved_q, saved_d;
	logic [teab_pkg::STATUS_W-1:0] stat_q, stat_d;
	logic [ECW-1:0] ecnt_q, ecnt_d;
	logic [FCW-1:0] fcnt_q, fcnt_d;
	logic solid_q, solid_d;
	logic [2:0][FIW-1:0] nb_q, nb_d;
	logic [2:0] mask_q, mask_d;
	logic [HW-1:0] init_q, init_d;
	teab_pkg::res_t res_q, res_d;
	logic res_valid_q, res_valid_d;

	logic [VERTEX_BITS-1:0] ep_p, ep_q;
	logic [KW-1:0] key_c;
	logic [HW-1:0] hash_c;
	logic [FCW+QW-1:0] fq_w, fc_w;
	logic shared_c;
	logic [FIW-1:0] first_c, second_c;

	function automatic logic [FFW-1:0] face_fld(input logic [FCW-1:0] v);
		logic [FCW+FFW-1:0] w;
		w = {{FFW{1'b0}}, v};
		return w[FFW-1:0];
	endfunction

	function automatic logic [FFW-1:0] fidx_fld(input logic [FIW-1:0] v);
		logic [FIW+FFW-1:0] w;
		w = {{FFW{1'b0}}, v};
		return w[FFW-1:0];
	endfunction

	function automatic logic [EDW-1:0] edge_fld(input logic [EIW-1:0] v);
		logic [EIW+EDW-1:0] w;
		w = {{EDW{1'b0}}, v};
		return w[EDW-1:0];
	endfunction

	// Fold the edge key into a table slot
	function automatic logic [HW-1:0] hash_of(input logic [KW-1:0] k);
		logic [HW-1:0] h;
		h = '0;
		for (int i = 0; i < KW; i++) h[i % HW] = h[i % HW] ^ k[i];
		return h;
	endfunction

	// Pick the two vertices of the current edge and form its key
	always_comb begin
		unique case (e_q)
			2'd1: begin
				ep_p = v_q[1];
				ep_q = v_q[2];
			end
			2'd2: begin
				ep_p = v_q[2];
				ep_q = v_q[0];
			end
			default: begin
				ep_p = v_q[0];
				ep_q = v_q[1];
			end
		endcase
		key_c = (ep_p < ep_q) ? {ep_p, ep_q} : {ep_q, ep_p};
		hash_c = hash_of(key_c);
	end

	assign fq_w = {{FCW{1'b0}}, head.fq};
	assign fc_w = {{QW{1'b0}}, fcnt_q};
	assign shared_c = efr_q[EFW-1];
	assign second_c = efr_q[2*FIW-1:FIW];
	assign first_c = efr_q[FIW-1:0];

	// Sequence each command
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		v_d = v_q;
		fi_d = fi_q;
		e_d = e_q;
		key_d = key_q;
		slot_d = slot_q;
		id_d = id_q;
		ids_d = ids_q;
		tn_d = tn_q;
		tid_d = tid_q;
		tfirst_d = tfirst_q;
		saved_d = saved_q;
		stat_d = stat_q;
		ecnt_d = ecnt_q;
		fcnt_d = fcnt_q;
		solid_d = solid_q;
		nb_d = nb_q;
		mask_d = mask_q;
		init_d = init_q;
		res_d = res_q;
		res_valid_d = res_valid_q && !res_ready;
		pop = 1'b0;
		hw_en = 1'b0;
		hw_addr = slot_q;
		hw_data = ecnt_q;
		hr_addr = slot_q;
		kw_en = 1'b0;
		kw_addr = ecnt_q[EIW-1:0];
		kw_data = key_q;
		kr_addr = id_q;
		efw_en = 1'b0;
		efw_addr = id_q;
		efw_data = efr_q;
		efr_addr = id_q;
		few_en = 1'b0;
		few_addr = fi_q[FIW-1:0];
		few_data = ids_q;
		fer_addr = fq_w[FIW-1:0];

		unique case (state_q)
			teab_pkg::ST_INIT: begin
				// Mark every hash slot empty
				hw_en = 1'b1;
				hw_addr = init_q;
				hw_data = '1;
				init_d = init_q + HW'(1);
				if (init_q == '1) state_d = teab_pkg::ST_IDLE;
			end
			teab_pkg::ST_IDLE: begin
				if (head_valid && !res_valid_q) begin
					pop = 1'b1;
					op_d = head.op;
					v_d[0] = head.va[VERTEX_BITS-1:0];
					v_d[1] = head.vb[VERTEX_BITS-1:0];
					v_d[2] = head.vc[VERTEX_BITS-1:0];
					res_d = '0;
					res_d.solid = solid_q;
					unique case (head.op)
						teab_pkg::OP_CLEAR: begin
							fcnt_d = '0;
							ecnt_d = '0;
							solid_d = 1'b1;
							res_d.solid = 1'b1;
							res_valid_d = 1'b1;
							// Sweep stale slots so probe chains stay short
							state_d = teab_pkg::ST_INIT;
						end
						teab_pkg::OP_ADD: begin
							if (fcnt_q >= FCW'(MAX_FACES)) begin
								res_d.status = teab_pkg::STAT_FULL;
								res_d.face = face_fld(fcnt_q);
								res_valid_d = 1'b1;
							end else begin
								fi_d = fcnt_q;
								e_d = 2'd0;
								tn_d = 2'd0;
								saved_d = ecnt_q;
								state_d = teab_pkg::ST_KEY;
							end
						end
						teab_pkg::OP_QUERY: begin
							if (fq_w >= fc_w) begin
								res_d.status = teab_pkg::STAT_BAD;
								res_d.face = head.fq;
								res_valid_d = 1'b1;
							end else begin
								fi_d = fq_w[FCW-1:0];
								state_d = teab_pkg::ST_FRD;
							end
						end
						default: res_valid_d = 1'b1;
					endcase
				end
			end
			teab_pkg::ST_KEY: begin
				key_d = key_c;
				slot_d = hash_c;
				hr_addr = hash_c;
				state_d = teab_pkg::ST_HCK;
			end
			teab_pkg::ST_HCK: begin
				if (hr_q >= ecnt_q) begin
					// Empty slot: the edge is new
					if (ecnt_q >= ECW'(MAX_EDGES)) begin
						stat_d = teab_pkg::STAT_FULL;
						state_d = teab_pkg::ST_RB;
					end else begin
						hw_en = 1'b1;
						kw_en = 1'b1;
						efw_en = 1'b1;
						efw_addr = ecnt_q[EIW-1:0];
						efw_data = {1'b1 ^ 1'b1, {FIW{1'b0}}, fi_q[FIW-1:0]};
						ids_d[e_q] = ecnt_q[EIW-1:0];
						ecnt_d = ecnt_q + ECW'(1);
						if (e_q == 2'd2) begin
							state_d = teab_pkg::ST_COMMIT;
						end else begin
							e_d = e_q + 2'd1;
							state_d = teab_pkg::ST_KEY;
						end
					end
				end else begin
					id_d = hr_q[EIW-1:0];
					kr_addr = hr_q[EIW-1:0];
					efr_addr = hr_q[EIW-1:0];
					state_d = teab_pkg::ST_ECK;
				end
			end
			teab_pkg::ST_ECK: begin
				if (kr_q == key_q) begin
					if (shared_c) begin
						stat_d = teab_pkg::STAT_OVER;
						solid_d = 1'b0;
						state_d = teab_pkg::ST_RB;
					end else begin
						// Record this face as the second user
						efw_en = 1'b1;
						efw_data = {1'b1, fi_q[FIW-1:0], first_c};
						tid_d[tn_q] = id_q;
						tfirst_d[tn_q] = first_c;
						tn_d = tn_q + 2'd1;
						ids_d[e_q] = id_q;
						if (e_q == 2'd2) begin
							state_d = teab_pkg::ST_COMMIT;
						end else begin
							e_d = e_q + 2'd1;
							state_d = teab_pkg::ST_KEY;
						end
					end
				end else begin
					// Probe the next slot
					slot_d = slot_q + HW'(1);
					hr_addr = slot_q + HW'(1);
					state_d = teab_pkg::ST_HCK;
				end
			end
			teab_pkg::ST_RB: begin
				if (tn_q != 2'd0) begin
					// Undo one second-user record
					efw_en = 1'b1;
					efw_addr = tid_q[tn_q - 2'd1];
					efw_data = {1'b0, {FIW{1'b0}}, tfirst_q[tn_q - 2'd1]};
					tn_d = tn_q - 2'd1;
				end else begin
					ecnt_d = saved_q;
					res_d = '0;
					res_d.status = stat_q;
					res_d.face = face_fld(fi_q);
					res_d.solid = solid_q;
					res_valid_d = 1'b1;
					state_d = teab_pkg::ST_IDLE;
				end
			end
			teab_pkg::ST_COMMIT: begin
				few_en = 1'b1;
				fcnt_d = fcnt_q + FCW'(1);
				e_d = 2'd0;
				state_d = teab_pkg::ST_DRD;
			end
			teab_pkg::ST_FRD: begin
				for (int i = 0; i < 3; i++) ids_d[i] = fer_q[i*EIW +: EIW];
				e_d = 2'd0;
				state_d = teab_pkg::ST_DRD;
			end
			teab_pkg::ST_DRD: begin
				efr_addr = ids_q[e_q];
				state_d = teab_pkg::ST_DCK;
			end
			teab_pkg::ST_DCK: begin
				// Neighbor across this edge
				if (shared_c) begin
					nb_d[e_q] = (first_c == fi_q[FIW-1:0]) ? second_c : first_c;
				end else begin
					nb_d[e_q] = '0;
				end
				mask_d[e_q] = !shared_c;
				if (e_q == 2'd2) begin
					state_d = teab_pkg::ST_FIN;
				end else begin
					e_d = e_q + 2'd1;
					state_d = teab_pkg::ST_DRD;
				end
			end
			teab_pkg::ST_FIN: begin
				res_d.status = (op_q == teab_pkg::OP_QUERY && mask_q != 3'b000) ?
					teab_pkg::STAT_OPEN : teab_pkg::STAT_OK;
				res_d.face = face_fld(fi_q);
				for (int i = 0; i < 3; i++) begin
					res_d.eid[i] = edge_fld(ids_q[i]);
					res_d.nb[i] = fidx_fld(nb_q[i]);
				end
				res_d.mask = mask_q;
				res_d.solid = solid_q;
				res_valid_d = 1'b1;
				state_d = teab_pkg::ST_IDLE;
			end
			default: state_d = teab_pkg::ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= teab_pkg::ST_INIT;
			init_q <= '0;
			fcnt_q <= '0;
			ecnt_q <= '0;
			solid_q <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q <= init_d;
			fcnt_q <= fcnt_d;
			ecnt_q <= ecnt_d;
			solid_q <= solid_d;
			res_valid_q <= res_valid_d;
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		op_q <= op_d;
		v_q <= v_d;
		fi_q <= fi_d;
		e_q <= e_d;
		key_q <= key_d;
		slot_q <= slot_d;
		id_q <= id_d;
		ids_q <= ids_d;
		tn_q <= tn_d;
		tid_q <= tid_d;
		tfirst_q <= tfirst_d;
		saved_q <= saved_d;
		stat_q <= stat_d;
		nb_q <= nb_d;
		mask_q <= mask_d;
		res_q <= res_d;
	end

	// Table memories, registered reads
	always_ff @(posedge clk) begin
		if (hw_en) hash_mem[hw_addr] <= hw_data;
		hr_q <= hash_mem[hr_addr];
	end

	always_ff @(posedge clk) begin
		if (kw_en) key_mem[kw_addr] <= kw_data;
		kr_q <= key_mem[kr_addr];
	end

	always_ff @(posedge clk) begin
		if (efw_en) ef_mem[efw_addr] <= efw_data;
		efr_q <= ef_mem[efr_addr];
	end

	always_ff @(posedge clk) begin
		if (few_en) fe_mem[few_addr] <= few_data;
		fer_q <= fe_mem[fer_addr];
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_ecnt: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= ECW'(MAX_EDGES)) else $error("edge count beyond table");
	a_fcnt: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= FCW'(MAX_FACES)) else $error("face count beyond table");
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !res_valid_q) else $error("command taken while result pending");
	a_rb_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == teab_pkg::ST_RB && tn_q == 2'd0) |=> res_valid_q)
		else $error("rejected face gave no result");

endmodule

// File: src/triangle_edge_adjacency_builder.sv
// Top level of the triangle edge adjacency builder: command queue, lookup
// engine and result packing. Depends on teab_pkg, teab_front, teab_engine.
//
// Usage: commands enter on the s_ channel (tuser: 0 clear, 1 add face,
// 2 query face); one result per command leaves on the m_ channel.
// An add looks up each edge of its triangle in turn in a hashed edge table:
// each lookup forms the key and reads the hash slot, and for a used slot also
// reads the stored key, probing the next slot on a collision; then come a
// face-table write and a read-back of the three neighbors. A query reads the
// face table and then the neighbors; an add to a full face table answers
// without a lookup, and a rejected add undoes each second-user record first.
// A clear answers first, then all 2*2^clog2(MAX_EDGES) hash slots (4096 by
// default) are swept before the next command is served; the same sweep
// runs after reset. Commands are queued meanwhile.
// A two-entry queue keeps taking commands while a result waits; the engine
// takes the next command only once it is idle and its result register is taken.
// When the receiver stalls, the result holds and the queue fills, then
// s_tready falls.
module triangle_edge_adjacency_builder #(
	parameter int MAX_FACES = 1024,
	parameter int MAX_EDGES = 1536,
	parameter int VERTEX_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// vertex_a[15:0], vertex_b[31:16], vertex_c[47:32], face_query[57:48]
	input logic [63:0] s_tdata,
	// command[1:0]
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// face_index[9:0], edge_id_0..2[42:10], neighbour_0..2[72:43],
	// open_mask[75:73], is_solid[76]
	output logic [79:0] m_tdata,
	// status[2:0]
	output logic [2:0] m_tuser
);

	logic head_valid;
	teab_pkg::cmd_t head;
	logic pop;
	teab_pkg::res_t res;

	teab_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.head_valid(head_valid),
		.head(head),
		.pop(pop)
	);

	teab_engine #(
		.MAX_FACES(MAX_FACES),
		.MAX_EDGES(MAX_EDGES),
		.VERTEX_BITS(VERTEX_BITS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res(res)
	);

	// Pack the result fields, lowest first
	assign m_tdata = {3'b000, res.solid, res.mask, res.nb[2], res.nb[1], res.nb[0],
		res.eid[2], res.eid[1], res.eid[0], res.face};
	assign m_tuser = res.status;

endmodule

// File: tb/sv/tb_triangle_edge_adjacency_builder.sv
`timescale 1ns / 100ps
// Self-checking testbench of the triangle edge adjacency builder: directed and
// random clear/add/query commands, predicted results checked in order.
// Depends on teab_pkg and triangle_edge_adjacency_builder.
module tb_triangle_edge_adjacency_builder;

	localparam int N_FACES = 1024;
	localparam int N_EDGES = 1536;
	localparam int CYCLE_LIMIT = 900000;
	localparam int HOLD_START = 5000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [1:0] cmd;
		logic [63:0] data;
	} cmd_item_t;

	typedef struct {
		logic [2:0] status;
		logic [79:0] data;
	} adj_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [2:0] m_tuser;

	triangle_edge_adjacency_builder u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	// Predictor state
	logic [31:0] key_store [N_EDGES];
	logic [9:0] first_user [N_EDGES];
	logic [9:0] second_user [N_EDGES];
	logic shared_bit [N_EDGES];
	logic [10:0] face_edge_ids [N_FACES][3];
	int faces_built;
	int edges_built;
	logic mesh_solid;

	cmd_item_t pending_cmds[$];
	adj_result_t expected_results[$];
	int error_count = 0;
	int cycle_count = 0;
	bit hold_off = 1'b0;
	bit sender_done = 0;

	function automatic logic [31:0] edge_key(logic [15:0] p, logic [15:0] q);
		return (p < q) ? {p, q} : {q, p};
	endfunction

	function automatic int lookup_edge(logic [31:0] key);
		for (int i = 0; i < edges_built; i++)
			if (key_store[i] == key) return i;
		return -1;
	endfunction

	// Pack edge ids, neighbors and open mask of a stored face
	function automatic logic [79:0] face_view(int f, output logic [2:0] mask);
		logic [79:0] d;
		logic [9:0] nb;
		logic [10:0] id;
		d = '0;
		mask = '0;
		for (int e = 0; e < 3; e++) begin
			id = face_edge_ids[f][e];
			nb = '0;
			if (shared_bit[id])
				nb = (int'(first_user[id]) == f) ? second_user[id] : first_user[id];
			else
				mask[e] = 1'b1;
			d[10 + 11*e +: 11] = id;
			d[43 + 10*e +: 10] = nb;
		end
		d[9:0] = 10'(f);
		d[75:73] = mask;
		return d;
	endfunction

	// Apply one command to the predictor and return its result
	function automatic adj_result_t predict_adjacency(cmd_item_t it);
		adj_result_t r;
		logic [15:0] v[3];
		int ids[3];
		int touched[$];
		int saved, idx;
		logic [31:0] key;
		logic [2:0] mask;
		int q;
		r.status = teab_pkg::STAT_OK;
		r.data = '0;
		case (it.cmd)
			teab_pkg::CMD_CLEAR: begin
				faces_built = 0;
				edges_built = 0;
				mesh_solid = 1'b1;
			end
			teab_pkg::CMD_ADD: begin
				r.data[9:0] = 10'(faces_built);
				saved = edges_built;
				v[0] = it.data[15:0];
				v[1] = it.data[31:16];
				v[2] = it.data[47:32];
				if (faces_built >= N_FACES) r.status = teab_pkg::STAT_FULL;
				for (int e = 0; e < 3 && r.status == teab_pkg::STAT_OK; e++) begin
					key = edge_key(v[e], v[(e + 1) % 3]);
					idx = lookup_edge(key);
					if (idx < 0) begin
						if (edges_built >= N_EDGES) r.status = teab_pkg::STAT_FULL;
						else begin
							idx = edges_built;
							edges_built++;
							key_store[idx] = key;
							first_user[idx] = 10'(faces_built);
							second_user[idx] = '0;
							shared_bit[idx] = 1'b0;
							ids[e] = idx;
						end
					end else if (shared_bit[idx]) begin
						r.status = teab_pkg::STAT_OVER;
						mesh_solid = 1'b0;
					end else begin
						second_user[idx] = 10'(faces_built);
						shared_bit[idx] = 1'b1;
						touched.insert(touched.size(), idx);
						ids[e] = idx;
					end
				end
				if (r.status != teab_pkg::STAT_OK) begin
					foreach (touched[k]) begin
						shared_bit[touched[k]] = 1'b0;
						second_user[touched[k]] = '0;
					end
					edges_built = saved;
				end else begin
					for (int e = 0; e < 3; e++) face_edge_ids[faces_built][e] = 11'(ids[e]);
					r.data = face_view(faces_built, mask);
					faces_built++;
				end
			end
			teab_pkg::CMD_QUERY: begin
				q = int'(it.data[57:48]);
				r.data[9:0] = 10'(q);
				if (q >= faces_built) r.status = teab_pkg::STAT_BAD;
				else begin
					r.data = face_view(q, mask);
					r.status = (mask != 3'b000) ? teab_pkg::STAT_OPEN : teab_pkg::STAT_OK;
				end
			end
			default: ;
		endcase
		r.data[76] = mesh_solid;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [79:0] got, logic [79:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	function automatic cmd_item_t make_cmd(logic [1:0] c, int a, int b, int cc, int q);
		cmd_item_t it;
		it.cmd = c;
		it.data = {6'd0, 10'(q), 16'(cc), 16'(b), 16'(a)};
		return it;
	endfunction

	task automatic queue_cmd(cmd_item_t it);
		pending_cmds.insert(pending_cmds.size(), it);
	endtask

	// Driver: one item per handshake, random gaps, predict on acceptance
	int gap = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (s_tvalid && s_tready) begin
			expected_results.insert(expected_results.size(),
				predict_adjacency(pending_cmds.pop_front()));
			gap = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) gap = 0;
		end
		if (!(s_tvalid && !s_tready)) begin
			if (gap > 0) begin
				gap--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() > 0 && arst_n
					&& pending_cmds[0].data[63] == 1'b0) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_cmds[0].cmd;
				s_tdata <= pending_cmds[0].data;
			end else begin
				s_tvalid <= 1'b0;
				// bit 63 marks a pause until all results are back
				if (pending_cmds.size() > 0 && pending_cmds[0].data[63] &&
						expected_results.size() == 0)
					void'(pending_cmds.pop_front());
			end
		end
	end

	// Long receiver hold-off while commands keep coming
	initial begin
		wait (arst_n);
		repeat (HOLD_START) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Monitor: random stall on the result side and field checks
	int stall = 0;
	always @(posedge clk) begin
		adj_result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0)
				report_mismatch("unexpected result", m_tdata, '0);
			else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", 80'(m_tuser), 80'(want.status));
				if (m_tdata[9:0] !== want.data[9:0])
					report_mismatch("face_index", 80'(m_tdata[9:0]), 80'(want.data[9:0]));
				for (int e = 0; e < 3; e++) begin
					if (m_tdata[10 + 11*e +: 11] !== want.data[10 + 11*e +: 11])
						report_mismatch($sformatf("edge_id_%0d", e),
							80'(m_tdata[10 + 11*e +: 11]), 80'(want.data[10 + 11*e +: 11]));
					if (m_tdata[43 + 10*e +: 10] !== want.data[43 + 10*e +: 10])
						report_mismatch($sformatf("neighbour_%0d", e),
							80'(m_tdata[43 + 10*e +: 10]), 80'(want.data[43 + 10*e +: 10]));
				end
				if (m_tdata[75:73] !== want.data[75:73])
					report_mismatch("open_mask", 80'(m_tdata[75:73]), 80'(want.data[75:73]));
				if (m_tdata[76] !== want.data[76])
					report_mismatch("is_solid", 80'(m_tdata[76]), 80'(want.data[76]));
			end
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) stall = 0;
		end
		if (hold_off) begin
			m_tready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	// Strip with shared edges over a small vertex pool, some far vertices and queries
	task automatic queue_mesh(int faces, int pool);
		int a, b, c;
		a = $urandom_range(0, pool);
		b = $urandom_range(0, pool);
		for (int i = 0; i < faces; i++) begin
			c = $urandom_range(0, pool);
			if ($urandom_range(0, 9) == 0) c = int'($urandom_range(0, 65535));
			queue_cmd(make_cmd(teab_pkg::CMD_ADD, a, b, c, $urandom));
			if ($urandom_range(0, 1)) a = c; else b = c;
			if ($urandom_range(0, 3) == 0)
				queue_cmd(make_cmd(teab_pkg::CMD_QUERY, $urandom, $urandom, $urandom,
					$urandom_range(0, i + 2)));
		end
	endtask

	task automatic queue_pause();
		cmd_item_t it;
		it.cmd = teab_pkg::CMD_CLEAR;
		it.data = 64'h8000_0000_0000_0000;
		queue_cmd(it);
	endtask

	initial begin
		faces_built = 0;
		edges_built = 0;
		mesh_solid = 1'b1;
		// Directed: queries on empty, extremes, degenerate faces, over-share, unused command
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 16'h0000, 16'hFFFF, 16'h1234, 10'h3FF));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 16'hFFFF, 16'h0000, 16'h5678, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 16'h0000, 16'hFFFF, 16'h9ABC, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 1));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 2));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF));
		queue_cmd(make_cmd(teab_pkg::CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 7, 7, 9, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 5, 5, 5, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 2));
		queue_cmd(make_cmd(teab_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 1, 2, 3, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 3, 2, 4, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_UNUSED, 0, 0, 0, 0));
		queue_pause();
		// Fill the edge table with distinct faces, overflow it, then reuse every edge
		// once more to fill the face table
		queue_cmd(make_cmd(teab_pkg::CMD_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < N_EDGES / 3; i++)
			queue_cmd(make_cmd(teab_pkg::CMD_ADD, 3*i, 3*i + 1, 3*i + 2, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, N_EDGES, N_EDGES + 1, N_EDGES + 2, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, N_EDGES / 3 - 1));
		for (int i = 0; i < N_FACES - N_EDGES / 3; i++)
			queue_cmd(make_cmd(teab_pkg::CMD_ADD, 3*i + 2, 3*i + 1, 3*i, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 0, 1, 2, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_ADD, 9, 10, 11, 0));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 10'h3FF));
		queue_cmd(make_cmd(teab_pkg::CMD_QUERY, 0, 0, 0, 5));
		queue_pause();
		// Random meshes, each after a clear, with occasional noise commands
		for (int k = 0; k < 15; k++) begin
			queue_cmd(make_cmd(teab_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
			queue_mesh($urandom_range(5, 20), $urandom_range(4, 40));
			if ($urandom_range(0, 4) == 0)
				queue_cmd(make_cmd(2'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom, $urandom));
			if (k == 7) queue_pause();
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_cmds.size() == 0);
		@(posedge clk);
		wait (!s_tvalid && expected_results.size() == 0);
		repeat (50) @(posedge clk);
		sender_done = 1;
	end

	// Run end and timeout
	initial begin
		wait (sender_done || cycle_count >= CYCLE_LIMIT);
		if (!sender_done) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			if (error_count == 0 && expected_results.size() == 0)
				$display("CHECK OK");
			else
				$display("CHECK FAILED");
			$finish;
		end
	end
endmodule

// File: sim.f
src/teab_pkg.sv
src/teab_front.sv
src/teab_engine.sv
src/triangle_edge_adjacency_builder.sv
tb/sv/tb_triangle_edge_adjacency_builder.sv
